// ----- design/blsd_pkg.sv -----
package blsd_pkg;

  localparam int BLOCK_COUNT_BITS = 20;

  localparam int CNT_W     = BLOCK_COUNT_BITS;
  localparam int MAG_W     = 15;
  localparam int SUM_W     = MAG_W + CNT_W;
  localparam int POS_W     = 32;
  localparam int BF_W      = 20;
  localparam int THR_W     = 15;
  localparam int LEVEL_W   = 15;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = $clog2(SUM_W + 1);

  localparam logic [31:0] COUNT_MAX = 32'((64'd1 << CNT_W) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FRAMES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_THRESHOLD = 2'd1;

  localparam logic [BF_W-1:0]  BLOCK_FRAMES_RST     = 20'd22050;
  localparam logic [THR_W-1:0] VOLUME_THRESHOLD_RST = 15'd20;

  typedef enum logic [1:0] {
    CLASS_SILENCE = 2'd0,
    CLASS_SIGNAL  = 2'd1,
    CLASS_UNKNOWN = 2'd2
  } class_e;

  typedef enum logic {
    BK_IDLE,
    BK_DIVIDE
  } back_state_e;

  // one closed block, handed from the accumulator to the back end
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] origin;
  } job_t;

  typedef struct packed {
    logic               kind;
    logic [POS_W-1:0]   start;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage

// ----- design/blsd_front.sv -----
module blsd_front
  import blsd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [15:0]     sample_i,
  input  logic            last_sample_i,
  input  logic [BF_W-1:0] block_frames_i,
  output logic            job_push_o,
  output job_t            job_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] origin_q, origin_d;
  logic [POS_W-1:0] pos_q, pos_d;

  logic [15:0]      neg;
  logic [MAG_W-1:0] mag;
  logic [31:0]      bf_ext;
  logic [31:0]      limit;
  logic [31:0]      cnt_next;
  logic [SUM_W-1:0] sum_next;
  logic             close;

  always_comb begin
    neg = 16'(~sample_i + 16'd1);
    if (!sample_i[15]) begin
      mag = sample_i[MAG_W-1:0];
    end else if (sample_i == 16'h8000) begin
      mag = {MAG_W{1'b1}};
    end else begin
      mag = neg[MAG_W-1:0];
    end

    bf_ext = 32'(block_frames_i);
    if (bf_ext == 32'd0) begin
      limit = 32'd1;
    end else if (bf_ext > COUNT_MAX) begin
      limit = COUNT_MAX;
    end else begin
      limit = bf_ext;
    end

    cnt_next = 32'(cnt_q) + 32'd1;
    sum_next = sum_q + SUM_W'(mag);
    close    = (cnt_next >= limit) || last_sample_i;

    sum_d    = sum_q;
    cnt_d    = cnt_q;
    origin_d = origin_q;
    pos_d    = pos_q;
    if (accept_i) begin
      pos_d = pos_q + 32'd1;
      if (close) begin
        sum_d    = '0;
        cnt_d    = '0;
        origin_d = pos_q + 32'd1;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_next[CNT_W-1:0];
      end
    end
  end

  assign job_push_o   = accept_i && close;
  assign job_o.sum    = sum_next;
  assign job_o.count  = cnt_next[CNT_W-1:0];
  assign job_o.origin = origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      origin_q <= '0;
      pos_q    <= '0;
    end else begin
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      origin_q <= origin_d;
      pos_q    <= pos_d;
    end
  end

endmodule

// ----- design/blsd_job_queue.sv -----
module blsd_job_queue
  import blsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= 2'(cnt_q + 2'(push_i) - 2'(pop_i));
    end
  end

endmodule

// ----- design/blsd_divider.sv -----
module blsd_divider
  import blsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [SUM_W-1:0] quotient_o
);

  // restoring division, one quotient bit per cycle; the dividend shifts out
  // of quo_q as the quotient shifts in
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[SUM_W-1]};
    diff    = shifted - {1'b0, div_q};
    fits    = (shifted >= {1'b0, div_q});
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- design/blsd_back.sv -----
module blsd_back
  import blsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  input  logic [THR_W-1:0] volume_threshold_i,
  input  logic             pop_i,
  output logic             empty_o,
  output result_t          result_o
);

  back_state_e state_q, state_d;
  class_e      last_class_q, last_class_d;
  logic [POS_W-1:0] origin_q;

  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quotient;

  logic [LEVEL_W-1:0] level;
  class_e             cls;
  logic               res_push;
  result_t            res_new;

  result_t    res_mem_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_pop;

  blsd_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (job_i.sum),
    .divisor_i  (job_i.count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    level = (|quotient[SUM_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : quotient[LEVEL_W-1:0];
    cls   = (level > volume_threshold_i) ? CLASS_SIGNAL : CLASS_SILENCE;

    res_new.kind  = (cls == CLASS_SIGNAL);
    res_new.start = origin_q;
    res_new.level = level;

    state_d      = state_q;
    last_class_d = last_class_q;
    div_start    = 1'b0;
    res_push     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        // only the back end fills the result queue, so room at start stays
        if (job_valid_i && (res_cnt_q != 2'd2)) begin
          div_start = 1'b1;
          state_d   = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (div_done) begin
          state_d = BK_IDLE;
          if (cls != last_class_q) begin
            res_push     = 1'b1;
            last_class_d = cls;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign job_pop_o = div_start;

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      origin_q <= job_i.origin;
    end
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

  assign res_pop  = pop_i && !empty_o;
  assign empty_o  = (res_cnt_q == 2'd0);
  assign result_o = res_mem_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      last_class_q <= CLASS_UNKNOWN;
      res_wr_q     <= 1'b0;
      res_rd_q     <= 1'b0;
      res_cnt_q    <= 2'd0;
    end else begin
      state_q      <= state_d;
      last_class_q <= last_class_d;
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
      res_cnt_q <= 2'(res_cnt_q + 2'(res_push) - 2'(res_pop));
    end
  end

endmodule

// ----- design/block_level_silence_detector_core.sv -----
// Block silence detector. One sample transfer is taken per cycle while the
// two-entry block queue between accumulator and back end has room. Each
// closed block then goes through the back end's serial divider, which makes
// one quotient bit per cycle; no new block starts until it is done. Blocks
// long enough for the divider to finish keep one sample per cycle; shorter
// blocks make full rise until the divider catches up. Results wait in a
// two-entry queue read through empty/pop. No clearing pass after reset.
module block_level_silence_detector_core
  import blsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [15:0]          sample_i,
  input  logic                 last_sample_i,
  output logic                 empty,
  input  logic                 pop,
  output logic                 event_kind_o,
  output logic [POS_W-1:0]     block_start_o,
  output logic [LEVEL_W-1:0]   block_level_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [BF_W-1:0]  block_frames_q;
  logic [THR_W-1:0] volume_threshold_q;

  logic    accept;
  logic    job_push;
  job_t    job_in;
  logic    job_full;
  logic    job_valid;
  logic    job_pop;
  job_t    job_out;
  result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_frames_q     <= BLOCK_FRAMES_RST;
      volume_threshold_q <= VOLUME_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BLOCK_FRAMES:     block_frames_q     <= cfg_data_i[BF_W-1:0];
        REG_VOLUME_THRESHOLD: volume_threshold_q <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  blsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .sample_i       (sample_i),
    .last_sample_i  (last_sample_i),
    .block_frames_i (block_frames_q),
    .job_push_o     (job_push),
    .job_o          (job_in)
  );

  blsd_job_queue u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  blsd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (job_valid),
    .job_i              (job_out),
    .job_pop_o          (job_pop),
    .volume_threshold_i (volume_threshold_q),
    .pop_i              (pop),
    .empty_o            (empty),
    .result_o           (result)
  );

  assign event_kind_o  = result.kind;
  assign block_start_o = result.start;
  assign block_level_o = result.level;

  a_job_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("block pushed into a full job queue");

  a_job_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("back end took a block from an empty job queue");

  a_pop_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |=> !job_pop)
    else $error("back end started two blocks in consecutive cycles");

endmodule
